FILE: rtl/core/cau_pkg.sv
// Shared types, request codes and saturation helpers of the complex arithmetic unit.
// Depends on nothing; every other file of the unit uses it by scoped names.
`default_nettype none

package cau_pkg;

    localparam int DW  = 16;          // bits per real or imaginary part
    localparam int FB  = 8;           // fraction bits
    localparam int NW  = 2 * DW;      // magnitude width of a product sum
    localparam int QN  = DW + 1;      // quotient and root bits, one per iteration stage
    localparam int SRW = DW + 2;      // square root remainder width

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_MAG  = 3'd4,
        OP_CONJ = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]           req_type;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        status_t              status;
    } res_t;

    // State of one request while it walks through the divider and root stages.
    typedef struct packed {
        logic [2:0]      op;
        res_t            simple;
        logic            dz;
        logic            re_neg;
        logic            im_neg;
        logic            re_ovf;
        logic            im_ovf;
        logic [NW-1:0]   d;
        logic [NW-1:0]   re_rem;
        logic [NW-1:0]   im_rem;
        logic [QN-1:0]   re_q;
        logic [QN-1:0]   im_q;
        logic [2*QN-1:0] sq_v;
        logic [SRW-1:0]  sq_rem;
        logic [QN-1:0]   sq_root;
    } iter_t;

    typedef struct packed {
        logic          sat;
        logic [DW-1:0] val;
    } satv_t;

    // Clamp a sign and magnitude pair to the signed part range.
    function automatic satv_t sat_mag(input logic neg, input logic [NW:0] mag);
        satv_t       r;
        logic [NW:0] lim;
        lim   = (NW+1)'(1) << (DW - 1);
        r.sat = 1'b0;
        if (neg) begin
            if (mag > lim) begin
                r.sat = 1'b1;
                r.val = lim[DW-1:0];
            end else begin
                r.val = (~mag[DW-1:0]) + DW'(1);
            end
        end else if (mag > lim - (NW+1)'(1)) begin
            r.sat = 1'b1;
            r.val = {1'b0, {(DW-1){1'b1}}};
        end else begin
            r.val = mag[DW-1:0];
        end
        return r;
    endfunction

    // Clamp a signed value one bit wider than a part.
    function automatic satv_t sat_sig(input logic signed [DW:0] x);
        logic signed [DW+1:0] xe;
        logic                 neg;
        neg = x[DW];
        xe  = {x[DW], x};
        if (neg) begin
            xe = -xe;
        end
        return sat_mag(neg, (NW+1)'($unsigned(xe)));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cau_front.sv
// Front end of the complex arithmetic unit: input register, products, sums and
// the setup of the divider and root iterations. Depends on cau_pkg.
`default_nettype none

module cau_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire cau_pkg::req_t in_req,
    output logic               out_vld,
    output cau_pkg::iter_t     out_st
);

    localparam int DW = cau_pkg::DW;
    localparam int NW = cau_pkg::NW;
    localparam int FB = cau_pkg::FB;
    localparam int QN = cau_pkg::QN;

    // Stage A: request register
    logic          a_vld_reg;
    cau_pkg::req_t a_reg;

    // Stage B: products
    logic                   b_vld_reg;
    logic [2:0]             b_op_reg;
    cau_pkg::res_t          b_simple_reg, b_simple_next;
    logic signed [NW-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [NW-1:0]   p_ar_reg, p_ai_reg, p_br_reg, p_bi_reg;

    // Stage C: sums
    logic                   c_vld_reg;
    logic [2:0]             c_op_reg;
    cau_pkg::res_t          c_simple_reg;
    logic signed [NW:0]     mr_reg, mi_reg, nr_reg, ni_reg;
    logic [NW-1:0]          d_reg, v_reg;

    // Stage D: setup
    logic                   d_vld_reg;
    cau_pkg::iter_t         st_reg, st_next;

    always_comb
    begin
        cau_pkg::satv_t s_re;
        cau_pkg::satv_t s_im;
        s_re          = '0;
        s_im          = '0;
        b_simple_next = '0;
        case (a_reg.req_type)
            cau_pkg::OP_ADD:
            begin
                s_re = cau_pkg::sat_sig((DW+1)'(a_reg.a_re) + (DW+1)'(a_reg.b_re));
                s_im = cau_pkg::sat_sig((DW+1)'(a_reg.a_im) + (DW+1)'(a_reg.b_im));
            end
            cau_pkg::OP_SUB:
            begin
                s_re = cau_pkg::sat_sig((DW+1)'(a_reg.a_re) - (DW+1)'(a_reg.b_re));
                s_im = cau_pkg::sat_sig((DW+1)'(a_reg.a_im) - (DW+1)'(a_reg.b_im));
            end
            cau_pkg::OP_CONJ:
            begin
                s_re.val = a_reg.a_re;
                s_im     = cau_pkg::sat_sig(-((DW+1)'(a_reg.a_im)));
            end
            default:
            begin
            end
        endcase
        b_simple_next.res_re = s_re.val;
        b_simple_next.res_im = s_im.val;
        b_simple_next.status = (s_re.sat || s_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end

    always_comb
    begin
        logic [NW:0]      mr_mag, mi_mag, nr_mag, ni_mag;
        logic [NW:0]      mr_sh, mi_sh;
        logic [NW+FB-1:0] xr, xi;
        cau_pkg::satv_t   s_re;
        cau_pkg::satv_t   s_im;
        mr_mag = mr_reg[NW] ? $unsigned(-mr_reg) : $unsigned(mr_reg);
        mi_mag = mi_reg[NW] ? $unsigned(-mi_reg) : $unsigned(mi_reg);
        nr_mag = nr_reg[NW] ? $unsigned(-nr_reg) : $unsigned(nr_reg);
        ni_mag = ni_reg[NW] ? $unsigned(-ni_reg) : $unsigned(ni_reg);
        mr_sh  = mr_mag >> FB;
        mi_sh  = mi_mag >> FB;
        s_re   = cau_pkg::sat_mag(mr_reg[NW] && (mr_sh != '0), mr_sh);
        s_im   = cau_pkg::sat_mag(mi_reg[NW] && (mi_sh != '0), mi_sh);

        st_next        = '0;
        st_next.op     = c_op_reg;
        st_next.simple = c_simple_reg;
        if (c_op_reg == cau_pkg::OP_MUL) begin
            st_next.simple.res_re = s_re.val;
            st_next.simple.res_im = s_im.val;
            st_next.simple.status = (s_re.sat || s_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end

        // The quotient keeps QN bits; anything that needs more has overflowed.
        xr             = {nr_mag[NW-1:0], {FB{1'b0}}};
        xi             = {ni_mag[NW-1:0], {FB{1'b0}}};
        st_next.dz     = (d_reg == '0);
        st_next.re_neg = nr_reg[NW];
        st_next.im_neg = ni_reg[NW];
        st_next.re_ovf = (NW+FB)'(xr[NW+FB-1:QN]) >= (NW+FB)'(d_reg);
        st_next.im_ovf = (NW+FB)'(xi[NW+FB-1:QN]) >= (NW+FB)'(d_reg);
        st_next.d      = d_reg;
        st_next.re_rem = NW'(xr[NW+FB-1:QN]);
        st_next.im_rem = NW'(xi[NW+FB-1:QN]);
        st_next.re_q   = xr[QN-1:0];
        st_next.im_q   = xi[QN-1:0];
        st_next.sq_v   = (2*QN)'(v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            a_reg        <= in_req;

            b_op_reg     <= a_reg.req_type;
            b_simple_reg <= b_simple_next;
            p_rr_reg     <= a_reg.a_re * a_reg.b_re;
            p_ii_reg     <= a_reg.a_im * a_reg.b_im;
            p_ri_reg     <= a_reg.a_re * a_reg.b_im;
            p_ir_reg     <= a_reg.a_im * a_reg.b_re;
            p_ar_reg     <= a_reg.a_re * a_reg.a_re;
            p_ai_reg     <= a_reg.a_im * a_reg.a_im;
            p_br_reg     <= a_reg.b_re * a_reg.b_re;
            p_bi_reg     <= a_reg.b_im * a_reg.b_im;

            c_op_reg     <= b_op_reg;
            c_simple_reg <= b_simple_reg;
            mr_reg       <= (NW+1)'(p_rr_reg) - (NW+1)'(p_ii_reg);
            mi_reg       <= (NW+1)'(p_ri_reg) + (NW+1)'(p_ir_reg);
            nr_reg       <= (NW+1)'(p_rr_reg) + (NW+1)'(p_ii_reg);
            ni_reg       <= (NW+1)'(p_ir_reg) - (NW+1)'(p_ri_reg);
            d_reg        <= NW'($unsigned(p_br_reg)) + NW'($unsigned(p_bi_reg));
            v_reg        <= NW'($unsigned(p_ar_reg)) + NW'($unsigned(p_ai_reg));

            st_reg       <= st_next;
        end
    end

    assign out_vld = d_vld_reg;
    assign out_st  = st_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cau_step.sv
// One iteration stage: a restoring divide step on both quotient parts and a
// digit step of the square root. Depends on cau_pkg.
`default_nettype none

module cau_step (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_vld,
    input  wire cau_pkg::iter_t in_st,
    output logic                out_vld,
    output cau_pkg::iter_t      out_st
);

    localparam int NW  = cau_pkg::NW;
    localparam int QN  = cau_pkg::QN;
    localparam int SRW = cau_pkg::SRW;

    logic           vld_reg;
    cau_pkg::iter_t st_reg, st_next;

    always_comb
    begin
        logic [NW:0]    r2_re, r2_im;
        logic           ge_re, ge_im, ge_sq;
        logic [SRW+1:0] rem4, trial;
        st_next = in_st;

        r2_re          = {in_st.re_rem, in_st.re_q[QN-1]};
        ge_re          = r2_re >= {1'b0, in_st.d};
        r2_re          = ge_re ? r2_re - {1'b0, in_st.d} : r2_re;
        st_next.re_rem = r2_re[NW-1:0];
        st_next.re_q   = {in_st.re_q[QN-2:0], ge_re};

        r2_im          = {in_st.im_rem, in_st.im_q[QN-1]};
        ge_im          = r2_im >= {1'b0, in_st.d};
        r2_im          = ge_im ? r2_im - {1'b0, in_st.d} : r2_im;
        st_next.im_rem = r2_im[NW-1:0];
        st_next.im_q   = {in_st.im_q[QN-2:0], ge_im};

        // Bring down two radicand bits and try the next root bit.
        rem4            = {in_st.sq_rem, in_st.sq_v[2*QN-1:2*QN-2]};
        trial           = (SRW+2)'({in_st.sq_root, 2'b01});
        ge_sq           = rem4 >= trial;
        rem4            = ge_sq ? rem4 - trial : rem4;
        st_next.sq_rem  = rem4[SRW-1:0];
        st_next.sq_root = {in_st.sq_root[QN-2:0], ge_sq};
        st_next.sq_v    = {in_st.sq_v[2*QN-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            st_reg <= st_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_st  = st_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cau_back.sv
// Back end: picks the result of the request type, saturates quotient and root,
// and holds the output register that drives the result channel. Depends on cau_pkg.
`default_nettype none

module cau_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_vld,
    input  wire cau_pkg::iter_t in_st,
    output logic                adv,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cau_pkg::res_t       out_res
);

    localparam int NW = cau_pkg::NW;

    logic          out_vld_reg;
    cau_pkg::res_t res_reg, res_next;

    assign adv = !out_vld_reg || out_ready;

    always_comb
    begin
        logic [NW:0]    q_re, q_im;
        cau_pkg::satv_t s_re;
        cau_pkg::satv_t s_im;
        q_re     = in_st.re_ovf ? '1 : (NW+1)'(in_st.re_q);
        q_im     = in_st.im_ovf ? '1 : (NW+1)'(in_st.im_q);
        s_re     = '0;
        s_im     = '0;
        res_next = in_st.simple;
        case (in_st.op)
            cau_pkg::OP_DIV:
            begin
                if (in_st.dz) begin
                    res_next.res_re = '0;
                    res_next.res_im = '0;
                    res_next.status = cau_pkg::ST_DIVZ;
                end else begin
                    s_re = cau_pkg::sat_mag(in_st.re_neg && (q_re != '0), q_re);
                    s_im = cau_pkg::sat_mag(in_st.im_neg && (q_im != '0), q_im);
                    res_next.res_re = s_re.val;
                    res_next.res_im = s_im.val;
                    res_next.status = (s_re.sat || s_im.sat) ? cau_pkg::ST_SAT
                                                             : cau_pkg::ST_OK;
                end
            end
            cau_pkg::OP_MAG:
            begin
                s_re = cau_pkg::sat_mag(1'b0, (NW+1)'(in_st.sq_root));
                res_next.res_re = s_re.val;
                res_next.res_im = '0;
                res_next.status = s_re.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

FILE: rtl/core/complex_arithmetic_unit_top.sv
// Complex arithmetic unit on signed Q8.8 operands: add, subtract, multiply,
// divide, magnitude and conjugate, with truncation toward zero and saturation.
// The unit accepts one request every cycle while the result side does not stall. Each
// result passes four front stages (request register, products, sums, divider setup),
// seventeen iteration stages that each form one quotient bit of both parts and one
// square root bit, and the output register.
// A stall on the result side holds the whole pipeline in place.
// Depends on cau_pkg, cau_front, cau_step and cau_back.
`default_nettype none

module complex_arithmetic_unit_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cau_pkg::req_t in_req,
    output logic               out_valid,
    input  wire logic          out_ready,
    output cau_pkg::res_t      out_res
);

    localparam int QN = cau_pkg::QN;

    logic           adv;
    logic           vld [QN+1];
    cau_pkg::iter_t st  [QN+1];

    assign in_ready = adv;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_req   (in_req),
        .out_vld  (vld[0]),
        .out_st   (st[0])
    );

    for (genvar i = 0; i < QN; i++) begin : g_step
        cau_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (vld[i]),
            .in_st   (st[i]),
            .out_vld (vld[i+1]),
            .out_st  (st[i+1])
        );
    end

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (vld[QN]),
        .in_st     (st[QN]),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

endmodule

`default_nettype wire

FILE: tb/sv/complex_arithmetic_unit_top_test.sv
// Self-checking testbench for the complex arithmetic unit: drives random and corner-case requests,
// predicts each result independently and compares it with what the unit returns.
// Depends on cau_pkg and complex_arithmetic_unit_top.
`timescale 1ns / 100ps

module complex_arithmetic_unit_top_test;

    localparam int DW         = cau_pkg::DW;
    localparam int FB         = cau_pkg::FB;
    localparam int LATENCY    = 22;
    localparam int MAX_CYCLES = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    cau_pkg::req_t in_req;
    logic out_valid;
    logic out_ready;
    cau_pkg::res_t out_res;

    cau_pkg::req_t pending_reqs[$];
    cau_pkg::res_t expected_results[$];

    int  mismatch_count;
    int  result_count;
    int  cycle_count;
    bit  stimulus_done;
    bit  quiet_phase;
    bit  hold_request;
    bit  in_taken;
    int  send_gap;
    int  recv_gap;
    int  hold_cycles;
    int  op_seen[8];

    complex_arithmetic_unit_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Sign and magnitude clamp to the part range; sets sat when it clips.
    function automatic logic [DW-1:0] clamp_part(input logic neg, input logic [63:0] mag,
                                                 inout logic sat);
        logic [63:0] lim;
        lim = 64'd1 << (DW - 1);
        if (mag == 0) begin
            return '0;
        end
        if (neg) begin
            if (mag > lim) begin
                sat = 1'b1;
                return lim[DW-1:0];
            end
            return DW'(-mag);
        end
        if (mag > lim - 1) begin
            sat = 1'b1;
            return DW'(lim - 1);
        end
        return mag[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] clamp_signed(input longint v, inout logic sat);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return clamp_part(v < 0, m, sat);
    endfunction

    // Quotient of mag * 2^FB over d toward zero, capped just past the range.
    function automatic logic [63:0] scaled_quotient(input logic [63:0] mag,
                                                    input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] lim;
        lim = 64'd1 << (DW - 1);
        q = mag / d;
        if (q > (lim >> FB)) begin
            return lim + 1;
        end
        return (mag << FB) / d;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= v) begin
                r = r | (64'd1 << b);
            end
        end
        return r;
    endfunction

    function automatic cau_pkg::res_t complex_result(input cau_pkg::req_t rq);
        cau_pkg::res_t r;
        logic          sat;
        longint        ar, ai, br, bi, re, im;
        logic [63:0]   d;
        longint        num;
        ar = longint'(rq.a_re);
        ai = longint'(rq.a_im);
        br = longint'(rq.b_re);
        bi = longint'(rq.b_im);
        sat = 1'b0;
        r.res_re = '0;
        r.res_im = '0;
        r.status = cau_pkg::ST_OK;
        case (rq.req_type)
            cau_pkg::OP_ADD: begin
                r.res_re = clamp_signed(ar + br, sat);
                r.res_im = clamp_signed(ai + bi, sat);
            end
            cau_pkg::OP_SUB: begin
                r.res_re = clamp_signed(ar - br, sat);
                r.res_im = clamp_signed(ai - bi, sat);
            end
            cau_pkg::OP_MUL: begin
                // Products are exact; the shift truncates the magnitude toward zero.
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
                r.res_re = clamp_part(re < 0, (re < 0 ? 64'(-re) : 64'(re)) >> FB, sat);
                r.res_im = clamp_part(im < 0, (im < 0 ? 64'(-im) : 64'(im)) >> FB, sat);
            end
            cau_pkg::OP_DIV: begin
                d = 64'(br * br + bi * bi);
                if (d == 0) begin
                    r.status = cau_pkg::ST_DIVZ;
                end else begin
                    num = ar * br + ai * bi;
                    r.res_re = clamp_part(num < 0,
                        scaled_quotient(num < 0 ? 64'(-num) : 64'(num), d), sat);
                    num = ai * br - ar * bi;
                    r.res_im = clamp_part(num < 0,
                        scaled_quotient(num < 0 ? 64'(-num) : 64'(num), d), sat);
                end
            end
            cau_pkg::OP_MAG: begin
                r.res_re = clamp_part(1'b0, int_sqrt(64'(ar * ar + ai * ai)), sat);
            end
            cau_pkg::OP_CONJ: begin
                r.res_re = rq.a_re;
                r.res_im = clamp_signed(-ai, sat);
            end
            default: begin
            end
        endcase
        if (r.status == cau_pkg::ST_OK && sat) begin
            r.status = cau_pkg::ST_SAT;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        mismatch_count++;
        $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got,
                 want);
    endtask

    function automatic logic [DW-1:0] edge_value();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            5: return 16'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cau_pkg::req_t random_request();
        cau_pkg::req_t rq;
        rq.req_type = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5));
        rq.a_re = edge_value();
        rq.a_im = edge_value();
        rq.b_re = edge_value();
        rq.b_im = ($urandom_range(0, 4) == 0) ? '0 : edge_value();
        return rq;
    endfunction

    function automatic cau_pkg::req_t make_req(input logic [2:0] op,
                                               input logic [DW-1:0] a_re,
                                               input logic [DW-1:0] a_im,
                                               input logic [DW-1:0] b_re,
                                               input logic [DW-1:0] b_im);
        cau_pkg::req_t rq;
        rq.req_type = op;
        rq.a_re = a_re;
        rq.a_im = a_im;
        rq.b_re = b_re;
        rq.b_im = b_im;
        return rq;
    endfunction

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        out_ready = 1'b0;
        // Directed corners: every operation at the range extremes, division by zero,
        // conjugate of the most negative imaginary part, and the unused codes.
        pending_reqs.push_back(make_req(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff,
                                        16'h8000));
        pending_reqs.push_back(make_req(cau_pkg::OP_ADD, 16'h0100, 16'hff00, 16'h0080,
                                        16'h0000));
        pending_reqs.push_back(make_req(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff,
                                        16'h8000));
        pending_reqs.push_back(make_req(cau_pkg::OP_SUB, 16'h0200, 16'h0100, 16'h0100,
                                        16'h0100));
        pending_reqs.push_back(make_req(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000,
                                        16'h8000));
        pending_reqs.push_back(make_req(cau_pkg::OP_MUL, 16'h0180, 16'hff80, 16'h0200,
                                        16'h0000));
        pending_reqs.push_back(make_req(cau_pkg::OP_MUL, 16'h0001, 16'h0000, 16'hffff,
                                        16'h0000));
        pending_reqs.push_back(make_req(cau_pkg::OP_DIV, 16'h0100, 16'h0100, 16'h0000,
                                        16'h0000));
        pending_reqs.push_back(make_req(cau_pkg::OP_DIV, 16'h0300, 16'h0100, 16'h0100,
                                        16'h0100));
        pending_reqs.push_back(make_req(cau_pkg::OP_DIV, 16'h7fff, 16'h7fff, 16'h0001,
                                        16'h0000));
        pending_reqs.push_back(make_req(cau_pkg::OP_DIV, 16'h8000, 16'h0000, 16'h8000,
                                        16'h8000));
        pending_reqs.push_back(make_req(cau_pkg::OP_DIV, 16'hff00, 16'h0000, 16'h0300,
                                        16'h0000));
        pending_reqs.push_back(make_req(cau_pkg::OP_MAG, 16'h8000, 16'h8000, 16'h1234,
                                        16'h5678));
        pending_reqs.push_back(make_req(cau_pkg::OP_MAG, 16'h0300, 16'h0400, 16'h0000,
                                        16'h0000));
        pending_reqs.push_back(make_req(cau_pkg::OP_MAG, 16'h0000, 16'h0000, 16'hffff,
                                        16'hffff));
        pending_reqs.push_back(make_req(cau_pkg::OP_CONJ, 16'h8000, 16'h8000, 16'h0000,
                                        16'h0000));
        pending_reqs.push_back(make_req(cau_pkg::OP_CONJ, 16'h7fff, 16'h7fff, 16'hffff,
                                        16'hffff));
        pending_reqs.push_back(make_req(3'd6, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0));
        pending_reqs.push_back(make_req(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        for (int i = 0; i < 1800; i++) begin
            pending_reqs.push_back(random_request());
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Request driver: changes inputs on the falling edge, with random idle bursts
    // until the last part of the run.
    always @(negedge clk) begin
        if (rst_n) begin
            quiet_phase <= (pending_reqs.size() < 200);
            if (in_taken) begin
                // Previous request was taken at the rising edge just passed.
                void'(pending_reqs.pop_front());
            end
            if (!in_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(1, 11) - 1;
                        in_valid <= 1'b0;
                    end else begin
                        in_valid <= 1'b1;
                        in_req <= pending_reqs[0];
                    end
                end else begin
                    in_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Long receiver hold-off early in the run, so the pipeline fills and stalls its input.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!hold_request && result_count == 40) begin
                hold_request <= 1'b1;
                hold_cycles <= 120;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_cycles > 1) begin
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Prediction on acceptance, and result checking.
    always @(posedge clk) begin
        cau_pkg::res_t want;
        if (rst_n) begin
            cycle_count <= cycle_count + 1;
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                expected_results.push_back(complex_result(in_req));
                op_seen[in_req.req_type]++;
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected res_re", out_res.res_re, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_res.res_re !== want.res_re) begin
                        report_mismatch("res_re", out_res.res_re, want.res_re);
                    end
                    if (out_res.res_im !== want.res_im) begin
                        report_mismatch("res_im", out_res.res_im, want.res_im);
                    end
                    if (out_res.status !== want.status) begin
                        report_mismatch("status", DW'(out_res.status), DW'(want.status));
                    end
                end
                result_count <= result_count + 1;
            end
        end
    end

    initial begin
        mismatch_count = 0;
        result_count = 0;
        cycle_count = 0;
        stimulus_done = 1'b0;
        quiet_phase = 1'b0;
        hold_request = 1'b0;
        in_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_cycles = 0;
        for (int i = 0; i < 8; i++) begin
            op_seen[i] = 0;
        end
        wait (rst_n);
        while (!(stimulus_done && !in_valid && expected_results.size() == 0)
               && cycle_count < MAX_CYCLES) begin
            @(posedge clk);
        end
        if (cycle_count >= MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_results.size());
            $display("** complex_arithmetic_unit_top: FAILED **");
        end else begin
            repeat (2 * LATENCY) @(posedge clk);
            $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d, mag %0d,",
                     result_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
                     op_seen[4]);
            $display("conj %0d, unused codes %0d, with random stalls on both sides %s",
                     op_seen[5], op_seen[6] + op_seen[7], "and a long output hold.");
            if (mismatch_count == 0 && expected_results.size() == 0) begin
                $display("** complex_arithmetic_unit_top: PASSED **");
            end else begin
                $display("** complex_arithmetic_unit_top: FAILED **");
            end
        end
        $finish;
    end

endmodule

FILE: complex_arithmetic_unit_top.f
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_step.sv
rtl/core/cau_back.sv
rtl/core/complex_arithmetic_unit_top.sv
tb/sv/complex_arithmetic_unit_top_test.sv
